@@ rtl/core/hbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants for the Huffman bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 24;

    localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 24;
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;
    localparam int WIN_W  = CODE_W + BYTE_W;
    localparam int TOT_W  = 5;
    localparam int USED_W = 3;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_RSVD   = 2'd3
    } hbp_mode_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } hbp_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              stream_end;
    } hbp_out_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } hbp_entry_t;

    typedef struct packed {
        logic align;
        logic shift;
        logic commit;
        logic clear;
    } hbp_pack_ctrl_t;

    typedef struct packed {
        logic [BYTE_W-1:0] top_byte;
        logic [TOT_W-1:0]  total;
        logic [BYTE_W-1:0] partial;
    } hbp_pack_stat_t;

endpackage

@@ rtl/core/hbp_code_table.sv @@
// ----------------------------------------------------------------------------
// hbp_code_table
// Code word and length store, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hbp_code_table (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [hbp_pkg::IDX_W-1:0] wr_addr,
    input  hbp_pkg::hbp_entry_t       wr_data,
    input  logic                      rd_en,
    input  logic [hbp_pkg::IDX_W-1:0] rd_addr,
    output hbp_pkg::hbp_entry_t       rd_data
);
    import hbp_pkg::*;

    hbp_entry_t mem [SYMBOL_COUNT];
    hbp_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/hbp_packer.sv @@
// ----------------------------------------------------------------------------
// hbp_packer
// Bit window and shift unit: aligns a code behind the pending bits, then
// shifts out one byte per step and keeps the partial byte.
// ----------------------------------------------------------------------------
module hbp_packer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hbp_pkg::hbp_pack_ctrl_t ctrl,
    input  hbp_pkg::hbp_entry_t    entry,
    output hbp_pkg::hbp_pack_stat_t stat
);
    import hbp_pkg::*;

    logic [WIN_W-1:0]  win_reg, win_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [BYTE_W-1:0] partial_reg, partial_next;
    logic [USED_W-1:0] used_reg, used_next;

    logic [LEN_W-1:0]  pad_amt;
    logic [CODE_W-1:0] code_left;

    // left-align code; bits above the length fall off the top
    assign pad_amt   = LEN_W'(CODE_W) - entry.len;
    assign code_left = entry.code << pad_amt;

    always_comb
    begin
        win_next     = win_reg;
        total_next   = total_reg;
        partial_next = partial_reg;
        used_next    = used_reg;
        if (ctrl.align)
        begin
            win_next   = {partial_reg, {CODE_W{1'b0}}}
                       | ({code_left, {BYTE_W{1'b0}}} >> used_reg);
            total_next = TOT_W'({2'b00, used_reg}) + TOT_W'(entry.len);
        end
        if (ctrl.shift)
        begin
            win_next   = {win_reg[WIN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            total_next = total_reg - TOT_W'(BYTE_W);
        end
        if (ctrl.commit)
        begin
            partial_next = win_reg[WIN_W-1 -: BYTE_W];
            used_next    = total_reg[USED_W-1:0];
        end
        if (ctrl.clear)
        begin
            partial_next = '0;
            used_next    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg   <= win_next;
        total_reg <= total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            used_reg    <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            used_reg    <= used_next;
        end
    end

    assign stat.top_byte = win_reg[WIN_W-1 -: BYTE_W];
    assign stat.total    = total_reg;
    assign stat.partial  = partial_reg;

endmodule

@@ rtl/core/huffman_bit_packer.sv @@
// ----------------------------------------------------------------------------
// huffman_bit_packer
// Huffman code bit packer: table load, symbol encode into bytes, flush.
//
//   channel  dir  handshake              payload
//   item     in   item_valid/item_stall  item      (mode, symbol, code)
//   byte     out  byte_valid/byte_stall  byte_data (out_byte, last, end)
//
// Load writes one table entry. Encode emits n output bytes (0..3) by way of the
// registered table read, the align step and one byte per cycle out of the
// shared shift unit while the output is not stalled. Flush emits the partial byte.
// Reset clears the partial byte and the sequencer; the table is not cleared.
// A stalled output holds the byte; the sequencer waits before the next byte.
// ----------------------------------------------------------------------------
module huffman_bit_packer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hbp_pkg::hbp_in_t  item,
    output logic              byte_valid,
    input  logic              byte_stall,
    output hbp_pkg::hbp_out_t byte_data
);
    import hbp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ALIGN = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic           byte_valid_reg, byte_valid_next;
    hbp_out_t       byte_data_reg, byte_data_next;

    logic           accept;
    logic           sym_ok;
    logic           out_free;
    logic           load_out;
    logic           wr_en;
    logic           rd_en;
    logic [LEN_W-1:0] sat_len;
    hbp_entry_t     wr_entry;
    hbp_entry_t     rd_entry;
    hbp_pack_ctrl_t pctrl;
    hbp_pack_stat_t pstat;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign sym_ok     = ({1'b0, item.symbol} < (SYM_W+1)'(SYMBOL_COUNT));
    assign out_free   = !byte_valid_reg || !byte_stall;

    assign sat_len  = (item.code_length > LEN_W'(MAX_CODE_LEN))
                    ? LEN_W'(MAX_CODE_LEN) : item.code_length;
    assign wr_entry = '{code: item.code_bits, len: sat_len};
    assign wr_en    = accept && (item.mode == MODE_LOAD) && sym_ok;
    assign rd_en    = accept && (item.mode == MODE_ENCODE) && sym_ok;

    hbp_code_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (item.symbol[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (item.symbol[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    hbp_packer u_packer (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (pctrl),
        .entry (rd_entry),
        .stat  (pstat)
    );

    always_comb
    begin
        state_next     = state_reg;
        pctrl          = '0;
        load_out       = 1'b0;
        byte_data_next = byte_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = ST_ALIGN;
                end
                else if (accept && (item.mode == MODE_FLUSH))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_ALIGN:
            begin
                pctrl.align = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (pstat.total < TOT_W'(BYTE_W))
                begin
                    pctrl.commit = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (out_free)
                begin
                    pctrl.shift    = 1'b1;
                    load_out       = 1'b1;
                    byte_data_next = '{out_byte:    pstat.top_byte,
                                       last_of_run: (pstat.total < TOT_W'(2*BYTE_W)),
                                       stream_end:  1'b0};
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    pctrl.clear    = 1'b1;
                    load_out       = 1'b1;
                    byte_data_next = '{out_byte:    pstat.partial,
                                       last_of_run: 1'b1,
                                       stream_end:  1'b1};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (load_out)
        begin
            byte_valid_next = 1'b1;
        end
        else if (!byte_stall)
        begin
            byte_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_data_reg <= byte_data_next;
    end

    assign byte_valid = byte_valid_reg;
    assign byte_data  = byte_data_reg;

    // encode request goes to align after the table read
    a_enc_align: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_ALIGN))
        else $error("encode request did not start align");

    a_align_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALIGN) |=> (state_reg == ST_EMIT))
        else $error("align not followed by emit");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && (pstat.total < TOT_W'(BYTE_W)))
        |=> (state_reg == ST_IDLE))
        else $error("emit did not finish with fewer than eight bits");

    // a held byte is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid_reg && byte_stall) |-> !load_out)
        else $error("output byte overwritten while stalled");

endmodule
